// ===== sv/two_level_writeback_cache_defines.svh =====
// assertion macros used by the request queue
`ifndef TWO_LEVEL_WRITEBACK_CACHE_DEFINES_SVH
`define TWO_LEVEL_WRITEBACK_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define TLWBC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TLWBC_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TLWBC_ASSERT(lbl, clk, rstn, prop, msg)
`define TLWBC_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== sv/tlwbc_pkg.sv =====
// shared types and constants of the two-level cache
package tlwbc_pkg;
	localparam int ADDR_BITS   = 20;
	localparam int MEM_AW      = ADDR_BITS - 2;
	localparam int BK_WORDS    = 1 << MEM_AW;
	localparam int NT_W        = ADDR_BITS - 14;
	localparam int FT_W        = ADDR_BITS - 15;
	localparam int NEAR_LINES  = 256;
	localparam int FAR_LINES   = 512;
	localparam int BLK_WORDS   = 16;
	localparam int IDX1_W      = 8;
	localparam int IDX2_W      = 9;
	localparam int CYC_W       = 11;

	localparam logic [2:0] REG_L1_READ  = 3'd0;
	localparam logic [2:0] REG_L1_WRITE = 3'd1;
	localparam logic [2:0] REG_L2_READ  = 3'd2;
	localparam logic [2:0] REG_L2_WRITE = 3'd3;
	localparam logic [2:0] REG_MEM_READ = 3'd4;
	localparam logic [2:0] REG_MEM_WRITE = 3'd5;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic [7:0] l1r;
		logic [7:0] l1w;
		logic [7:0] l2r;
		logic [7:0] l2w;
		logic [7:0] memr;
		logic [7:0] memw;
	} cost_t;

	typedef struct packed {
		logic                   wr;
		logic                   err;
		logic [ADDR_BITS-1:2]   addr;
		logic [31:0]            wdata;
	} req_t;

	typedef struct packed {
		logic            v;
		logic            d;
		logic [NT_W-1:0] tag;
	} nmeta_t;

	typedef struct packed {
		logic            v;
		logic            d;
		logic [FT_W-1:0] tag;
	} fmeta_t;
endpackage

// ===== sv/tlwbc_front.sv =====
// front end: takes requests, checks the address range, hands them to the queue
module tlwbc_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [31:0]       address,
	input  logic [31:0]       write_data,
	input  logic              clearing,
	input  logic              q_ready,
	output logic              q_push,
	output tlwbc_pkg::req_t   q_entry
);
	import tlwbc_pkg::*;

	logic out_of_range;

	assign out_of_range = {1'b0, address} >= (33'd1 << ADDR_BITS);
	// no requests while memory is being cleared after reset
	assign in_ready = q_ready & ~clearing;
	assign q_push   = in_valid & in_ready;

	always_comb begin
		q_entry.wr    = op;
		q_entry.err   = out_of_range;
		q_entry.addr  = address[ADDR_BITS-1:2];
		q_entry.wdata = write_data;
	end
endmodule

// ===== sv/tlwbc_queue.sv =====
// two-entry request queue between front and back end
`include "two_level_writeback_cache_defines.svh"
module tlwbc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tlwbc_pkg::req_t push_data,
	output logic            ready,
	output logic            valid,
	input  logic            pop,
	output tlwbc_pkg::req_t pop_data
);
	import tlwbc_pkg::*;

	req_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign ready    = cnt_q != 2'd2;
	assign valid    = cnt_q != 2'd0;
	assign pop_data = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`TLWBC_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3, "queue count out of range")
	`TLWBC_NEVER(a_no_overflow, clk, arst_n, push && cnt_q == 2'd2, "push into full queue")
	`TLWBC_NEVER(a_no_underflow, clk, arst_n, pop && cnt_q == 2'd0, "pop from empty queue")
	`TLWBC_ASSERT(a_ptr_gap, clk, arst_n, (cnt_q == 2'd1) == (wp_q != rp_q), "pointers disagree with count")
endmodule

// ===== sv/tlwbc_back.sv =====
// back end: tag lookups, block moves between the levels and word access
module tlwbc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tlwbc_pkg::cost_t  cost,
	input  logic              req_valid,
	input  tlwbc_pkg::req_t   req,
	output logic              req_pop,
	output logic              clearing,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       read_data,
	output logic [10:0]       access_cycles,
	output logic [31:0]       elapsed_time,
	output logic              first_level_hit,
	output logic              address_error
);
	import tlwbc_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_NLOOK = 4'd2;
	localparam logic [3:0] S_NTAG  = 4'd3;
	localparam logic [3:0] S_FLOOK = 4'd4;
	localparam logic [3:0] S_FTAG  = 4'd5;
	localparam logic [3:0] S_FWB   = 4'd6;
	localparam logic [3:0] S_FILL  = 4'd7;
	localparam logic [3:0] S_FMETA = 4'd8;
	localparam logic [3:0] S_VSAVE = 4'd9;
	localparam logic [3:0] S_NFILL = 4'd10;
	localparam logic [3:0] S_VWR   = 4'd11;
	localparam logic [3:0] S_WORD  = 4'd12;
	localparam logic [3:0] S_RD    = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	// memories
	logic [31:0] bk_mem [BK_WORDS];
	logic [31:0] far_mem [FAR_LINES*BLK_WORDS];
	logic [31:0] near_mem [NEAR_LINES*BLK_WORDS];
	nmeta_t      nmeta_mem [NEAR_LINES];
	fmeta_t      fmeta_mem [FAR_LINES];

	logic              bk_we;
	logic [MEM_AW-1:0] bk_waddr, bk_raddr;
	logic [31:0]       bk_wdata, bk_rd_q;
	logic              far_we;
	logic [12:0]       far_waddr, far_raddr;
	logic [31:0]       far_wdata, far_rd_q;
	logic              near_we;
	logic [11:0]       near_waddr, near_raddr;
	logic [31:0]       near_wdata, near_rd_q;
	logic              nm_we;
	logic [IDX1_W-1:0] nm_waddr;
	nmeta_t            nm_wdata, nm_rd_q;
	logic              fm_we;
	logic [IDX2_W-1:0] fm_waddr;
	fmeta_t            fm_wdata, fm_rd_q;

	logic [3:0]            state_q;
	logic [4:0]            cnt_q;
	logic [MEM_AW-1:0]     clr_cnt_q;
	logic                  wr_q, err_q;
	logic [ADDR_BITS-1:2]  addr_q;
	logic [31:0]           wdata_q, rdata_q;
	logic                  nv_q, nd_q, hit_q;
	logic [NT_W-1:0]       ntag_q;
	logic                  fmode_q, fhit_q, fd_q;
	logic [IDX2_W-1:0]     idx2_q;
	logic [FT_W-1:0]       tag2_q, ftag_old_q;
	logic [CYC_W-1:0]      charged_q;
	logic [31:0]           vbuf_q [BLK_WORDS];
	logic                  out_valid_q, hit_o_q, err_o_q;
	logic [31:0]           rdata_o_q, time_q;
	logic [CYC_W-1:0]      cyc_o_q;

	logic [IDX1_W-1:0] idx1;
	logic [NT_W-1:0]   tag1;
	logic [3:0]        word;
	logic [3:0]        ri, wi;
	logic              wr_on, copy_end;
	logic              fhit;
	logic [CYC_W-1:0]  total;
	logic              out_free;
	logic              done_fire;

	assign idx1     = addr_q[13:6];
	assign tag1     = addr_q[ADDR_BITS-1:14];
	assign word     = addr_q[5:2];
	assign ri       = cnt_q[3:0];
	assign wi       = 4'(cnt_q - 5'd1);
	assign wr_on    = cnt_q != 5'd0;
	assign copy_end = cnt_q == 5'd16;
	assign fhit     = fm_rd_q.v && fm_rd_q.tag == tag2_q;
	assign total    = charged_q + (err_q ? '0 : (wr_q ? CYC_W'(cost.l1w) : CYC_W'(cost.l1r)));
	assign out_free = ~out_valid_q | out_ready;
	assign done_fire = state_q == S_DONE && out_free;

	assign clearing        = state_q == S_CLR;
	assign req_pop         = state_q == S_IDLE && req_valid;
	assign out_valid       = out_valid_q;
	assign read_data       = rdata_o_q;
	assign access_cycles   = cyc_o_q;
	assign elapsed_time    = time_q;
	assign first_level_hit = hit_o_q;
	assign address_error   = err_o_q;

	// memory port control
	always_comb begin
		bk_we      = 1'b0;
		bk_waddr   = {ftag_old_q, idx2_q, wi};
		bk_wdata   = far_rd_q;
		bk_raddr   = {tag2_q, idx2_q, ri};
		far_we     = 1'b0;
		far_waddr  = {idx2_q, wi};
		far_wdata  = bk_rd_q;
		far_raddr  = {idx2_q, ri};
		near_we    = 1'b0;
		near_waddr = {idx1, wi};
		near_wdata = far_rd_q;
		near_raddr = {idx1, ri};
		nm_we      = 1'b0;
		nm_waddr   = idx1;
		nm_wdata   = '{v: 1'b1, d: wr_q | (hit_q & nd_q), tag: tag1};
		fm_we      = 1'b0;
		fm_waddr   = idx2_q;
		fm_wdata   = '{v: 1'b1, d: fmode_q | (fhit_q & fd_q), tag: tag2_q};
		unique case (state_q)
			S_CLR: begin
				bk_we    = 1'b1;
				bk_waddr = clr_cnt_q;
				bk_wdata = '0;
				nm_we    = 1'b1;
				nm_waddr = clr_cnt_q[IDX1_W-1:0];
				nm_wdata = '0;
				fm_we    = 1'b1;
				fm_waddr = clr_cnt_q[IDX2_W-1:0];
				fm_wdata = '0;
			end
			S_FWB:   bk_we   = wr_on;
			S_FILL:  far_we  = wr_on;
			S_NFILL: near_we = wr_on;
			S_VWR: begin
				far_we    = wr_on;
				far_wdata = vbuf_q[wi];
			end
			S_FMETA: fm_we = 1'b1;
			S_WORD: begin
				nm_we      = 1'b1;
				near_raddr = {idx1, word};
				near_we    = wr_q;
				near_waddr = {idx1, word};
				near_wdata = wdata_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bk_we) bk_mem[bk_waddr] <= bk_wdata;
		bk_rd_q <= bk_mem[bk_raddr];
	end

	always_ff @(posedge clk) begin
		if (far_we) far_mem[far_waddr] <= far_wdata;
		far_rd_q <= far_mem[far_raddr];
	end

	always_ff @(posedge clk) begin
		if (near_we) near_mem[near_waddr] <= near_wdata;
		near_rd_q <= near_mem[near_raddr];
	end

	always_ff @(posedge clk) begin
		if (nm_we) nmeta_mem[nm_waddr] <= nm_wdata;
		nm_rd_q <= nmeta_mem[idx1];
	end

	always_ff @(posedge clk) begin
		if (fm_we) fmeta_mem[fm_waddr] <= fm_wdata;
		fm_rd_q <= fmeta_mem[idx2_q];
	end

	// victim line held while the new block lands in level one
	always_ff @(posedge clk) begin
		if (state_q == S_VSAVE && wr_on) begin
			vbuf_q[wi] <= near_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			clr_cnt_q   <= '0;
			wr_q        <= 1'b0;
			err_q       <= 1'b0;
			addr_q      <= '0;
			wdata_q     <= '0;
			rdata_q     <= '0;
			nv_q        <= 1'b0;
			nd_q        <= 1'b0;
			hit_q       <= 1'b0;
			ntag_q      <= '0;
			fmode_q     <= 1'b0;
			fhit_q      <= 1'b0;
			fd_q        <= 1'b0;
			idx2_q      <= '0;
			tag2_q      <= '0;
			ftag_old_q  <= '0;
			charged_q   <= '0;
			hit_o_q     <= 1'b0;
			err_o_q     <= 1'b0;
			rdata_o_q   <= '0;
			cyc_o_q     <= '0;
			time_q      <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (&clr_cnt_q) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						wr_q      <= req.wr;
						err_q     <= req.err;
						addr_q    <= req.addr;
						wdata_q   <= req.wdata;
						rdata_q   <= '0;
						hit_q     <= 1'b0;
						charged_q <= '0;
						state_q   <= req.err ? S_DONE : S_NLOOK;
					end
				end
				S_NLOOK: state_q <= S_NTAG;
				S_NTAG: begin
					nv_q   <= nm_rd_q.v;
					nd_q   <= nm_rd_q.d;
					ntag_q <= nm_rd_q.tag;
					if (nm_rd_q.v && nm_rd_q.tag == tag1) begin
						hit_q   <= 1'b1;
						state_q <= S_WORD;
					end else begin
						idx2_q  <= addr_q[14:6];
						tag2_q  <= addr_q[ADDR_BITS-1:15];
						fmode_q <= 1'b0;
						state_q <= S_FLOOK;
					end
				end
				S_FLOOK: state_q <= S_FTAG;
				S_FTAG: begin
					fhit_q     <= fhit;
					fd_q       <= fm_rd_q.d;
					ftag_old_q <= fm_rd_q.tag;
					priority if (fhit) begin
						state_q <= fmode_q ? S_VWR : S_FMETA;
					end else if (fm_rd_q.v && fm_rd_q.d) begin
						charged_q <= charged_q + CYC_W'(cost.memr) + CYC_W'(cost.memw);
						state_q   <= S_FWB;
					end else begin
						charged_q <= charged_q + CYC_W'(cost.memr);
						state_q   <= S_FILL;
					end
				end
				S_FWB: begin
					cnt_q <= cnt_q + 1'b1;
					if (copy_end) begin
						cnt_q   <= '0;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (copy_end) begin
						cnt_q   <= '0;
						state_q <= fmode_q ? S_VWR : S_FMETA;
					end
				end
				S_VWR: begin
					cnt_q <= cnt_q + 1'b1;
					if (copy_end) begin
						cnt_q   <= '0;
						state_q <= S_FMETA;
					end
				end
				S_FMETA: begin
					charged_q <= charged_q + (fmode_q ? CYC_W'(cost.l2w) : CYC_W'(cost.l2r));
					priority if (fmode_q) state_q <= S_WORD;
					else if (nv_q && nd_q) state_q <= S_VSAVE;
					else state_q <= S_NFILL;
				end
				S_VSAVE: begin
					cnt_q <= cnt_q + 1'b1;
					if (copy_end) begin
						cnt_q   <= '0;
						state_q <= S_NFILL;
					end
				end
				S_NFILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (copy_end) begin
						cnt_q <= '0;
						// dirty level-one victim goes to level two next
						if (nv_q && nd_q) begin
							idx2_q  <= {ntag_q[0], idx1};
							tag2_q  <= ntag_q[NT_W-1:1];
							fmode_q <= 1'b1;
							state_q <= S_FLOOK;
						end else begin
							state_q <= S_WORD;
						end
					end
				end
				S_WORD: state_q <= wr_q ? S_DONE : S_RD;
				S_RD: begin
					rdata_q <= near_rd_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						rdata_o_q   <= rdata_q;
						cyc_o_q     <= total;
						time_q      <= time_q + 32'(total);
						hit_o_q     <= hit_q;
						err_o_q     <= err_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/two_level_writeback_cache.sv =====
// top level: cost registers, front end, request queue and back end
// Word read/write cache model: direct-mapped write-back L1 (256 x 64 B) and
// L2 (512 x 64 B) in front of a 2^20-byte backing memory.
// Requests arrive on in_valid/in_ready with op, address and write_data; one
// result per request leaves on out_valid/out_ready carrying the read word,
// the cycles charged, the running total, the L1 hit flag and the range error.
// Cost registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle: the block itself does not enforce it.
// Every block move copies a line word by word through the word memories.
// One request is worked on at a time; the back-end sequencer and its block
// copies set the rate.
// A two-entry queue takes requests while the back end is busy or its result
// waits; a stalled receiver holds the result and the back end after it.
// After reset the backing memory and both tag stores are cleared, one word a
// cycle, during which in_ready is low; cost registers return to their defaults
// and the running total to zero.
module two_level_writeback_cache (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [10:0] access_cycles,
	output logic [31:0] elapsed_time,
	output logic        first_level_hit,
	output logic        address_error,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import tlwbc_pkg::*;

	cost_t cost_q;
	req_t  push_data, pop_data;
	logic  q_push, q_ready, q_valid, q_pop, clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q <= '{l1r: 8'd1, l1w: 8'd1, l2r: 8'd10, l2w: 8'd10,
				memr: 8'd100, memw: 8'd50};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_L1_READ:   cost_q.l1r  <= cfg_data;
				REG_L1_WRITE:  cost_q.l1w  <= cfg_data;
				REG_L2_READ:   cost_q.l2r  <= cfg_data;
				REG_L2_WRITE:  cost_q.l2w  <= cfg_data;
				REG_MEM_READ:  cost_q.memr <= cfg_data;
				REG_MEM_WRITE: cost_q.memw <= cfg_data;
				default: ;
			endcase
		end
	end

	tlwbc_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.address    (address),
		.write_data (write_data),
		.clearing   (clearing),
		.q_ready    (q_ready),
		.q_push     (q_push),
		.q_entry    (push_data)
	);

	tlwbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.ready     (q_ready),
		.valid     (q_valid),
		.pop       (q_pop),
		.pop_data  (pop_data)
	);

	tlwbc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cost            (cost_q),
		.req_valid       (q_valid),
		.req             (pop_data),
		.req_pop         (q_pop),
		.clearing        (clearing),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.read_data       (read_data),
		.access_cycles   (access_cycles),
		.elapsed_time    (elapsed_time),
		.first_level_hit (first_level_hit),
		.address_error   (address_error)
	);
endmodule

// ===== test/tb.sv =====
// self-checking testbench for the two-level write-back cache
`timescale 1ns / 1ps

module tb;
	import tlwbc_pkg::*;

	typedef struct packed {
		logic [31:0] rdata;
		logic [10:0] cycles;
		logic [31:0] total;
		logic        hit;
		logic        err;
	} cache_resp_t;

	typedef struct {
		logic        wr;
		logic [31:0] addr;
		logic [31:0] wdata;
		logic        known;
		cache_resp_t resp;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [31:0] address;
	logic [31:0] write_data;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] read_data;
	logic [10:0] access_cycles;
	logic [31:0] elapsed_time;
	logic        first_level_hit;
	logic        address_error;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	two_level_writeback_cache dut (.*);

	localparam int MEM_WORDS = 1 << (ADDR_BITS - 2);

	// predictor state
	logic [31:0] p_near_data [NEAR_LINES*BLK_WORDS];
	logic [NT_W-1:0] p_near_tag [NEAR_LINES];
	logic        p_near_v [NEAR_LINES];
	logic        p_near_d [NEAR_LINES];
	logic [31:0] p_far_data [FAR_LINES*BLK_WORDS];
	logic [FT_W-1:0] p_far_tag [FAR_LINES];
	logic        p_far_v [FAR_LINES];
	logic        p_far_d [FAR_LINES];
	logic [31:0] p_mem [MEM_WORDS];
	logic [31:0] p_total;
	logic [31:0] p_charge;
	cost_t       p_cost;

	cache_resp_t expected_q[$];
	int          fails;
	bit          rx_hold;
	logic [31:0] blk_buf [BLK_WORDS];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic predictor_reset();
		for (int i = 0; i < NEAR_LINES; i++) begin
			p_near_v[i] = 0;
			p_near_d[i] = 0;
		end
		for (int i = 0; i < FAR_LINES; i++) begin
			p_far_v[i] = 0;
			p_far_d[i] = 0;
		end
		for (int i = 0; i < MEM_WORDS; i++)
			p_mem[i] = '0;
		p_total = '0;
		p_cost = '{l1r: 8'd1, l1w: 8'd1, l2r: 8'd10, l2w: 8'd10, memr: 8'd100, memw: 8'd50};
	endtask

	// far level access with a block; addr is block aligned
	function automatic void far_block(input logic [31:0] addr, input bit wr);
		int idx;
		logic [31:0] fetched [BLK_WORDS];
		int base;
		int vbase;
		idx = (addr >> 6) & 9'h1FF;
		base = (addr >> 2) & (MEM_WORDS - 1) & ~(BLK_WORDS - 1);
		if (!p_far_v[idx] || p_far_tag[idx] != FT_W'(addr >> 15)) begin
			for (int w = 0; w < BLK_WORDS; w++)
				fetched[w] = p_mem[base + w];
			p_charge += p_cost.memr;
			if (p_far_v[idx] && p_far_d[idx]) begin
				vbase = ((({27'd0, p_far_tag[idx]} << 15) + (idx << 6)) >> 2)
					& (MEM_WORDS - 1) & ~(BLK_WORDS - 1);
				for (int w = 0; w < BLK_WORDS; w++)
					p_mem[vbase + w] = p_far_data[idx*BLK_WORDS + w];
				p_charge += p_cost.memw;
			end
			for (int w = 0; w < BLK_WORDS; w++)
				p_far_data[idx*BLK_WORDS + w] = fetched[w];
			p_far_v[idx] = 1;
			p_far_tag[idx] = FT_W'(addr >> 15);
			p_far_d[idx] = 0;
		end
		for (int w = 0; w < BLK_WORDS; w++) begin
			if (wr)
				p_far_data[idx*BLK_WORDS + w] = blk_buf[w];
			else
				blk_buf[w] = p_far_data[idx*BLK_WORDS + w];
		end
		if (wr) begin
			p_charge += p_cost.l2w;
			p_far_d[idx] = 1;
		end else begin
			p_charge += p_cost.l2r;
		end
	endfunction

	function automatic cache_resp_t cache_access_predict(logic wr, logic [31:0] a_in,
			logic [31:0] wd);
		cache_resp_t r;
		logic [31:0] a;
		int idx;
		int word;
		logic [31:0] fetched [BLK_WORDS];
		a = a_in & ~32'd3;
		r = '0;
		if (a >= (32'd1 << ADDR_BITS)) begin
			r.total = p_total;
			r.err = 1;
			return r;
		end
		p_charge = 0;
		idx = (a >> 6) & 8'hFF;
		word = (a >> 2) & 4'hF;
		r.hit = p_near_v[idx] && p_near_tag[idx] == NT_W'(a >> 14);
		if (!r.hit) begin
			far_block(a & ~32'h3F, 0);
			fetched = blk_buf;
			if (p_near_v[idx] && p_near_d[idx]) begin
				for (int w = 0; w < BLK_WORDS; w++)
					blk_buf[w] = p_near_data[idx*BLK_WORDS + w];
				far_block(({26'd0, p_near_tag[idx]} << 14) + (idx << 6), 1);
			end
			for (int w = 0; w < BLK_WORDS; w++)
				p_near_data[idx*BLK_WORDS + w] = fetched[w];
			p_near_v[idx] = 1;
			p_near_tag[idx] = NT_W'(a >> 14);
			p_near_d[idx] = 0;
		end
		if (wr == OP_READ) begin
			r.rdata = p_near_data[idx*BLK_WORDS + word];
			p_charge += p_cost.l1r;
		end else begin
			p_near_data[idx*BLK_WORDS + word] = wd;
			p_charge += p_cost.l1w;
			p_near_d[idx] = 1;
		end
		p_total += p_charge;
		r.cycles = p_charge[10:0];
		r.total = p_total;
		return r;
	endfunction

	// valid stays up between back-to-back requests; it drops only for a gap
	task automatic send_request(logic wr, logic [31:0] a, logic [31:0] wd, bit gaps,
			bit known, cache_resp_t typed);
		cache_resp_t r;
		if (gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
				@(posedge clk);
		end
		in_valid <= 1;
		op <= wr;
		address <= a;
		write_data <= wd;
		do @(posedge clk); while (!in_ready);
		r = cache_access_predict(wr, a, wd);
		if (known && r != typed)
			$error("predictor disagrees with typed row for address %h", a);
		expected_q.push_back(known ? typed : r);
	endtask

	task automatic drain_results();
		in_valid <= 0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_cost(logic [2:0] ix, logic [7:0] v);
		cfg_we <= 1;
		cfg_index <= ix;
		cfg_data <= v;
		@(posedge clk);
		case (ix)
			REG_L1_READ:   p_cost.l1r = v;
			REG_L1_WRITE:  p_cost.l1w = v;
			REG_L2_READ:   p_cost.l2r = v;
			REG_L2_WRITE:  p_cost.l2w = v;
			REG_MEM_READ:  p_cost.memr = v;
			REG_MEM_WRITE: p_cost.memw = v;
			default: ;
		endcase
	endtask

	// addresses concentrated on a few tags so lines are evicted often
	function automatic logic [31:0] pick_address();
		logic [31:0] a;
		case ($urandom_range(0, 9))
			0: a = $urandom();
			1: a = $urandom_range(0, (1 << ADDR_BITS) - 1);
			default: a = ($urandom_range(0, 7) << 14) | ($urandom_range(0, 3) << 6)
				| $urandom_range(0, 63);
		endcase
		return a;
	endfunction

	// receiver
	always @(posedge clk) begin
		cache_resp_t exp_r;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding");
					fails++;
				end else begin
					exp_r = expected_q.pop_front();
					if (read_data !== exp_r.rdata) begin
						$error("read_data exp %h got %h", exp_r.rdata, read_data);
						fails++;
					end
					if (access_cycles !== exp_r.cycles) begin
						$error("access_cycles exp %0d got %0d", exp_r.cycles, access_cycles);
						fails++;
					end
					if (elapsed_time !== exp_r.total) begin
						$error("elapsed_time exp %0d got %0d", exp_r.total, elapsed_time);
						fails++;
					end
					if (first_level_hit !== exp_r.hit) begin
						$error("first_level_hit exp %b got %b", exp_r.hit, first_level_hit);
						fails++;
					end
					if (address_error !== exp_r.err) begin
						$error("address_error exp %b got %b", exp_r.err, address_error);
						fails++;
					end
				end
			end
			out_ready <= !rx_hold && ($urandom_range(0, 3) != 0);
		end
	end

	// long receiver hold-off, counted here
	initial begin
		rx_hold = 0;
		wait (arst_n);
		do @(posedge clk); while (!in_valid);
		repeat (600) @(posedge clk);
		rx_hold = 1;
		repeat (1500) @(posedge clk);
		rx_hold = 0;
	end

	initial begin
		#500ms;
		$display("FAIL two_level_writeback_cache");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		logic [2:0] ix;
		fails = 0;
		arst_n = 0;
		in_valid = 0;
		op = OP_READ;
		address = '0;
		write_data = '0;
		cfg_we = 0;
		cfg_index = REG_L1_READ;
		cfg_data = '0;
		predictor_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// directed rows; typed where obvious
		rows = '{
			'{OP_READ, 32'h0000_0000, 32'h0, 1, '{32'h0, 11'd111, 32'd111, 1'b0, 1'b0}},
			'{OP_READ, 32'h0000_0004, 32'h0, 1, '{32'h0, 11'd1, 32'd112, 1'b1, 1'b0}},
			'{OP_WRITE, 32'h0010_0000, 32'hDEAD_BEEF, 1, '{32'h0, 11'd0, 32'd112, 1'b0, 1'b1}},
			'{OP_READ, 32'hFFFF_FFFF, 32'h0, 1, '{32'h0, 11'd0, 32'd112, 1'b0, 1'b1}},
			'{OP_WRITE, 32'h0000_0007, 32'hFFFF_FFFF, 1, '{32'h0, 11'd1, 32'd113, 1'b1, 1'b0}},
			'{OP_READ, 32'h0000_0004, 32'h0, 0, '0},
			'{OP_WRITE, 32'h000F_FFFC, 32'hA5A5_5A5A, 0, '0},
			'{OP_READ, 32'h000F_FFFF, 32'h0, 0, '0},
			'{OP_WRITE, 32'h0000_4000, 32'h1234_5678, 0, '0},
			'{OP_READ, 32'h0000_0000, 32'h0, 0, '0},
			'{OP_WRITE, 32'h0000_8000, 32'h5555_AAAA, 0, '0},
			'{OP_READ, 32'h0000_4004, 32'h0, 0, '0},
			'{OP_WRITE, 32'h0008_0000, 32'h0F0F_F0F0, 0, '0},
			'{OP_READ, 32'h0000_0004, 32'h0, 0, '0},
			'{OP_READ, 32'h0008_0000, 32'h0, 0, '0},
			'{OP_READ, 32'h0000_4000, 32'h0, 0, '0}
		};
		wait (arst_n);
		foreach (rows[i]) begin
			row = rows[i];
			send_request(row.wr, row.addr, row.wdata, 0, row.known, row.resp);
		end

		// cost settings, extremes included; sender pauses until idle each time
		for (int phase = 0; phase < 5; phase++) begin
			drain_results();
			for (int r = 0; r < 6; r++) begin
				ix = r[2:0];
				case (phase)
					0: write_cost(ix, 8'd0);
					1: write_cost(ix, 8'd255);
					default: write_cost(ix, 8'($urandom()));
				endcase
			end
			write_cost(3'd7, 8'($urandom()));
			cfg_we <= 0;
			for (int n = 0; n < 400; n++)
				send_request(logic'($urandom_range(0, 1)), pick_address(), $urandom(), 1, 0, '0);
		end

		drain_results();
		if (fails == 0)
			$display("PASS two_level_writeback_cache");
		else
			$display("FAIL two_level_writeback_cache");
		$finish;
	end
endmodule
